// ===== sv/keyword_token_classifier_top_assert.svh =====
// Assertion macros shared by the keyword token classifier modules.
`ifndef KEYWORD_TOKEN_CLASSIFIER_TOP_ASSERT_SVH
`define KEYWORD_TOKEN_CLASSIFIER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define KTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define KTC_ASSERT(lbl, prop, msg)
`define KTC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/ktc_pkg.sv =====
// Package: class codes, character constants and queue entry type.
package ktc_pkg;

  localparam int MAX_TOKEN_CHARS_DEF = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_USCORE = 8'h5F;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;

  typedef enum logic [2:0] {
    GEN_NONE  = 3'd0,
    GEN_TYPE  = 3'd1,
    GEN_OP    = 3'd2,
    GEN_NAME  = 3'd3,
    GEN_VALUE = 3'd4,
    GEN_END   = 3'd5
  } gen_class_e;

  typedef enum logic [3:0] {
    SPEC_NONE    = 4'd0,
    SPEC_INT     = 4'd1,
    SPEC_STRING  = 4'd2,
    SPEC_BOOL    = 4'd3,
    SPEC_ASSIGN  = 4'd4,
    SPEC_COMPARE = 4'd5,
    SPEC_ADD     = 4'd6,
    SPEC_SUB     = 4'd7,
    SPEC_MUL     = 4'd8,
    SPEC_DIV     = 4'd9,
    SPEC_NAME    = 4'd10,
    SPEC_VALUE   = 4'd11,
    SPEC_END     = 4'd12
  } spec_class_e;

  typedef struct packed {
    logic        has_tok;
    logic        has_end;
    gen_class_e  gen;
    spec_class_e spec;
    logic [3:0]  len;
    logic [63:0] lo;
    logic [47:0] hi;
    logic        trunc;
  } entry_t;

endpackage

// ===== sv/ktc_front.sv =====
// Front end: token store, delimiter detection and classification.
`include "keyword_token_classifier_top_assert.svh"
module ktc_front import ktc_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam int CntW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int IdxW = $clog2(MAX_TOKEN_CHARS);

  logic [MAX_TOKEN_CHARS-1:0][7:0] store_q;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            ovf_q, ovf_d;
  logic [15:0][7:0]                pad;
  logic                            accept, is_delim, is_semi, has_tok, full;
  logic                            wr_en, clr;
  gen_class_e                      gen;
  spec_class_e                     spec;
  logic [7:0]                      f;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_semi    = (char_code_i == CHAR_SEMI);
  assign is_delim   = is_semi || (char_code_i == CHAR_SPACE) ||
                      (char_code_i >= CHAR_TAB && char_code_i <= CHAR_CR);
  assign has_tok    = (count_q != '0);
  assign full       = (count_q == CntW'(MAX_TOKEN_CHARS));
  assign wr_en      = accept && !is_delim && !full;
  assign clr        = accept && is_delim && has_tok;

  always_comb begin
    pad = '0;
    for (int i = 0; i < MAX_TOKEN_CHARS && i < 16; i++) begin
      pad[i] = store_q[i];
    end
  end

  assign f = pad[0];

  always_comb begin
    gen  = GEN_NONE;
    spec = SPEC_NONE;
    if (count_q == CntW'(3) && pad[0] == "i" && pad[1] == "n" && pad[2] == "t") begin
      gen  = GEN_TYPE;
      spec = SPEC_INT;
    end else if (count_q == CntW'(6) && pad[0] == "s" && pad[1] == "t" &&
                 pad[2] == "r" && pad[3] == "i" && pad[4] == "n" && pad[5] == "g") begin
      gen  = GEN_TYPE;
      spec = SPEC_STRING;
    end else if (count_q == CntW'(4) && pad[0] == "b" && pad[1] == "o" &&
                 pad[2] == "o" && pad[3] == "l") begin
      gen  = GEN_TYPE;
      spec = SPEC_BOOL;
    end else if (count_q == CntW'(1) && pad[0] == "=") begin
      gen  = GEN_OP;
      spec = SPEC_ASSIGN;
    end else if (count_q == CntW'(2) && pad[0] == "=" && pad[1] == "=") begin
      gen  = GEN_OP;
      spec = SPEC_COMPARE;
    end else if (count_q == CntW'(1) && pad[0] == "+") begin
      gen  = GEN_OP;
      spec = SPEC_ADD;
    end else if (count_q == CntW'(1) && pad[0] == "-") begin
      gen  = GEN_OP;
      spec = SPEC_SUB;
    end else if (count_q == CntW'(1) && pad[0] == "*") begin
      gen  = GEN_OP;
      spec = SPEC_MUL;
    end else if (count_q == CntW'(1) && pad[0] == "/") begin
      gen  = GEN_OP;
      spec = SPEC_DIV;
    end else if ((f >= "A" && f <= "Z") || (f >= "a" && f <= "z") ||
                 f == CHAR_USCORE || f == CHAR_DOLLAR) begin
      gen  = GEN_NAME;
      spec = SPEC_NAME;
    end else if ((f >= "0" && f <= "9") || f == CHAR_DQUOTE || f == CHAR_SQUOTE) begin
      gen  = GEN_VALUE;
      spec = SPEC_VALUE;
    end
  end

  always_comb begin
    entry_o.has_tok = has_tok;
    entry_o.has_end = is_semi;
    entry_o.gen     = gen;
    entry_o.spec    = spec;
    entry_o.len     = (int'(count_q) > 15) ? 4'd15 : 4'(count_q);
    entry_o.lo      = pad[7:0];
    entry_o.hi      = pad[13:8];
    entry_o.trunc   = ovf_q;
  end

  assign push_o = accept && is_delim && (has_tok || is_semi);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (clr) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end else if (accept && !is_delim) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (clr) begin
        store_q <= '0;
      end else if (wr_en) begin
        store_q[count_q[IdxW-1:0]] <= char_code_i;
      end
    end
  end

  `KTC_ASSERT(a_count_bound, count_q <= CntW'(MAX_TOKEN_CHARS), "token count past store size")
  `KTC_ASSERT(a_ovf_only_full, ovf_q |-> full, "overflow flag set with room in store")
  `KTC_ASSERT(a_clear_after_push, (push_o && has_tok) |=> (count_q == '0 && !ovf_q),
              "store not cleared after token transfer")

endmodule

// ===== sv/ktc_fifo.sv =====
// Two-entry queue between the classifier front end and the result back end.
`include "keyword_token_classifier_top_assert.svh"
module ktc_fifo import ktc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `KTC_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty queue")
  `KTC_ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")

endmodule

// ===== sv/ktc_back.sv =====
// Back end: expands queue entries into token and end results.
`include "keyword_token_classifier_top_assert.svh"
module ktc_back import ktc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  general_class_o,
  output logic [3:0]  specific_class_o,
  output logic [3:0]  token_length_o,
  output logic [63:0] text_first_bytes_o,
  output logic [47:0] text_last_bytes_o,
  output logic        was_truncated_o,
  output logic        last_of_run_o
);

  logic        vld_q, vld_d;
  logic        phase_q, phase_d;
  logic        load, tok_turn;
  gen_class_e  gen_q, gen_d;
  spec_class_e spec_q, spec_d;
  logic [3:0]  len_q, len_d;
  logic [63:0] lo_q, lo_d;
  logic [47:0] hi_q, hi_d;
  logic        trunc_q, trunc_d, last_q, last_d;

  assign load     = (!vld_q || !out_stall_i) && !empty_i;
  assign tok_turn = head_i.has_tok && !phase_q;

  always_comb begin
    vld_d   = vld_q && out_stall_i;
    phase_d = phase_q;
    pop_o   = 1'b0;
    gen_d   = gen_q;
    spec_d  = spec_q;
    len_d   = len_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    trunc_d = trunc_q;
    last_d  = last_q;
    if (load) begin
      vld_d = 1'b1;
      if (tok_turn) begin
        gen_d   = head_i.gen;
        spec_d  = head_i.spec;
        len_d   = head_i.len;
        lo_d    = head_i.lo;
        hi_d    = head_i.hi;
        trunc_d = head_i.trunc;
        last_d  = !head_i.has_end;
        phase_d = head_i.has_end;
        pop_o   = !head_i.has_end;
      end else begin
        gen_d   = GEN_END;
        spec_d  = SPEC_END;
        len_d   = 4'd1;
        lo_d    = 64'(CHAR_SEMI);
        hi_d    = '0;
        trunc_d = 1'b0;
        last_d  = 1'b1;
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q   <= gen_d;
    spec_q  <= spec_d;
    len_q   <= len_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    trunc_q <= trunc_d;
    last_q  <= last_d;
  end

  assign out_valid_o        = vld_q;
  assign general_class_o    = gen_q;
  assign specific_class_o   = spec_q;
  assign token_length_o     = len_q;
  assign text_first_bytes_o = lo_q;
  assign text_last_bytes_o  = hi_q;
  assign was_truncated_o    = trunc_q;
  assign last_of_run_o      = last_q;

  `KTC_ASSERT(a_phase_head, phase_q |-> (!empty_i && head_i.has_tok && head_i.has_end),
              "pending end result without matching queue head")

endmodule

// ===== sv/keyword_token_classifier_top.sv =====
// Top level of the keyword token classifier.
// Takes one byte per cycle on the input channel while in_stall_o is low and
// groups non-delimiter bytes (delimiters are space, tab through carriage
// return, and ';') into tokens of up to MAX_TOKEN_CHARS bytes; on a delimiter
// the token is classified as type, operator, name, value or none and
// transferred out, and a ';' adds an END result. The front end takes a new
// byte whenever the queue is not full; a ';' that closes a token yields two
// results, which the back end sends one after the other while a two-entry
// queue keeps the front end taking bytes. Only a further ';' directly behind
// such a ';' fills the queue and stalls the input; a stalled output backs up
// into the input once the queue holds two entries. Bytes beyond the store are
// dropped and flagged on the token's result. Results pass through the queue
// and leave from an output register.
module keyword_token_classifier_top import ktc_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  general_class_o,
  output logic [3:0]  specific_class_o,
  output logic [3:0]  token_length_o,
  output logic [63:0] text_first_bytes_o,
  output logic [47:0] text_last_bytes_o,
  output logic        was_truncated_o,
  output logic        last_of_run_o
);

  logic   push, pop, q_full, q_empty;
  entry_t entry, head;

  ktc_front #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (entry)
  );

  ktc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  ktc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (q_empty),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .general_class_o    (general_class_o),
    .specific_class_o   (specific_class_o),
    .token_length_o     (token_length_o),
    .text_first_bytes_o (text_first_bytes_o),
    .text_last_bytes_o  (text_last_bytes_o),
    .was_truncated_o    (was_truncated_o),
    .last_of_run_o      (last_of_run_o)
  );

endmodule

// ===== sim/keyword_token_classifier_top_tb.sv =====
// Self-checking testbench for the keyword token classifier, driven by directed and random byte streams.
`timescale 1ns / 100ps

module keyword_token_classifier_top_tb;
  import ktc_pkg::*;

  localparam int STORE_CHARS = MAX_TOKEN_CHARS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int TOTAL_ITEMS = 1650;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct {
    gen_class_e  gen;
    spec_class_e spec;
    logic [3:0]  len;
    logic [63:0] head_text;
    logic [47:0] tail_text;
    logic        trunc;
    logic        run_done;
  } token_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  general_class_o;
  logic [3:0]  specific_class_o;
  logic [3:0]  token_length_o;
  logic [63:0] text_first_bytes_o;
  logic [47:0] text_last_bytes_o;
  logic        was_truncated_o;
  logic        last_of_run_o;

  logic [7:0]    tok_chars [STORE_CHARS];
  int            tok_count = 0;
  bit            tok_overflow = 1'b0;
  token_result_t expected_tokens [$];

  string keyword_list [9] = '{"int", "string", "bool", "=", "==", "+", "-", "*", "/"};

  int mismatch_count = 0;
  int cycle_count = 0;
  int sent_count = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int rx_hold_left = 0;
  int rx_burst_left = 0;

  keyword_token_classifier_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .char_code_i        (char_code_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .general_class_o    (general_class_o),
    .specific_class_o   (specific_class_o),
    .token_length_o     (token_length_o),
    .text_first_bytes_o (text_first_bytes_o),
    .text_last_bytes_o  (text_last_bytes_o),
    .was_truncated_o    (was_truncated_o),
    .last_of_run_o      (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit is_delim(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SEMI;
  endfunction

  function automatic bit token_equals(string w);
    if (tok_count != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (tok_chars[i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic token_result_t classify_token();
    token_result_t r;
    logic [7:0] f;
    f = tok_chars[0];
    r.gen = GEN_NONE;
    r.spec = SPEC_NONE;
    if (token_equals("int")) begin
      r.gen = GEN_TYPE; r.spec = SPEC_INT;
    end else if (token_equals("string")) begin
      r.gen = GEN_TYPE; r.spec = SPEC_STRING;
    end else if (token_equals("bool")) begin
      r.gen = GEN_TYPE; r.spec = SPEC_BOOL;
    end else if (token_equals("=")) begin
      r.gen = GEN_OP; r.spec = SPEC_ASSIGN;
    end else if (token_equals("==")) begin
      r.gen = GEN_OP; r.spec = SPEC_COMPARE;
    end else if (token_equals("+")) begin
      r.gen = GEN_OP; r.spec = SPEC_ADD;
    end else if (token_equals("-")) begin
      r.gen = GEN_OP; r.spec = SPEC_SUB;
    end else if (token_equals("*")) begin
      r.gen = GEN_OP; r.spec = SPEC_MUL;
    end else if (token_equals("/")) begin
      r.gen = GEN_OP; r.spec = SPEC_DIV;
    end else if ((f >= "A" && f <= "Z") || (f >= "a" && f <= "z") ||
                 f == CHAR_USCORE || f == CHAR_DOLLAR) begin
      r.gen = GEN_NAME; r.spec = SPEC_NAME;
    end else if ((f >= "0" && f <= "9") || f == CHAR_DQUOTE || f == CHAR_SQUOTE) begin
      r.gen = GEN_VALUE; r.spec = SPEC_VALUE;
    end
    r.len = (tok_count > 15) ? 4'd15 : 4'(tok_count);
    r.head_text = '0;
    r.tail_text = '0;
    for (int i = 0; i < tok_count && i < 14; i++) begin
      if (i < 8) r.head_text[8*i +: 8] = tok_chars[i];
      else r.tail_text[8*(i-8) +: 8] = tok_chars[i];
    end
    r.trunc = tok_overflow;
    r.run_done = 1'b0;
    return r;
  endfunction

  function automatic void tokenize_byte(logic [7:0] c);
    token_result_t tok;
    token_result_t fin;
    bit is_semi;
    if (!is_delim(c)) begin
      if (tok_count < STORE_CHARS) begin
        tok_chars[tok_count] = c;
        tok_count++;
      end else begin
        tok_overflow = 1'b1;
      end
      return;
    end
    is_semi = (c == CHAR_SEMI);
    if (tok_count != 0) begin
      tok = classify_token();
      tok.run_done = !is_semi;
      expected_tokens.push_back(tok);
      foreach (tok_chars[i]) tok_chars[i] = '0;
      tok_count = 0;
      tok_overflow = 1'b0;
    end
    if (is_semi) begin
      fin.gen = GEN_END;
      fin.spec = SPEC_END;
      fin.len = 4'd1;
      fin.head_text = 64'(CHAR_SEMI);
      fin.tail_text = '0;
      fin.trunc = 1'b0;
      fin.run_done = 1'b1;
      expected_tokens.push_back(fin);
    end
  endfunction

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at cycle %0d, %s: expected %h, got %h", cycle_count, field, want, got);
  endtask

  // check each result transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    token_result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          note_mismatch("unexpected result", '0, 64'(general_class_o));
        end else begin
          e = expected_tokens.pop_front();
          if (general_class_o !== e.gen)
            note_mismatch("general_class", 64'(e.gen), 64'(general_class_o));
          if (specific_class_o !== e.spec)
            note_mismatch("specific_class", 64'(e.spec), 64'(specific_class_o));
          if (token_length_o !== e.len)
            note_mismatch("token_length", 64'(e.len), 64'(token_length_o));
          if (text_first_bytes_o !== e.head_text)
            note_mismatch("text_first_bytes", e.head_text, text_first_bytes_o);
          if (text_last_bytes_o !== e.tail_text)
            note_mismatch("text_last_bytes", 64'(e.tail_text), 64'(text_last_bytes_o));
          if (was_truncated_o !== e.trunc)
            note_mismatch("was_truncated", 64'(e.trunc), 64'(was_truncated_o));
          if (last_of_run_o !== e.run_done)
            note_mismatch("last_of_run", 64'(e.run_done), 64'(last_of_run_o));
        end
      end
      if (rx_hold_left > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_left--;
      end else if (rx_burst_left > 0) begin
        out_stall_i <= 1'b1;
        rx_burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        rx_burst_left = $urandom_range(0, 8);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    tokenize_byte(c);
    sent_count++;
  endtask

  task automatic send_word(input string w, input logic [7:0] delim);
    for (int i = 0; i < w.len(); i++) send_byte(w[i]);
    send_byte(delim);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [7:0] any_token_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_delim(c));
    return c;
  endfunction

  function automatic logic [7:0] any_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
  endfunction

  task automatic send_random_token();
    int kind;
    int n;
    string w;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 30) begin
      w = keyword_list[$urandom_range(0, 8)];
      for (int i = 0; i < w.len(); i++) send_byte(w[i]);
    end else if (kind < 38) begin
      w = keyword_list[$urandom_range(0, 8)];
      if ($urandom_range(0, 1) == 0 && w.len() > 1) begin
        for (int i = 0; i < w.len() - 1; i++) send_byte(w[i]);
      end else begin
        for (int i = 0; i < w.len(); i++) send_byte(w[i]);
        send_byte(any_token_byte());
      end
    end else if (kind < 60) begin
      case ($urandom_range(0, 3))
        0: send_byte(8'("A" + $urandom_range(0, 25)));
        1: send_byte(8'("a" + $urandom_range(0, 25)));
        2: send_byte(CHAR_USCORE);
        default: send_byte(CHAR_DOLLAR);
      endcase
      n = $urandom_range(0, 7);
      repeat (n) send_byte(any_token_byte());
    end else if (kind < 78) begin
      case ($urandom_range(0, 2))
        0: send_byte(8'("0" + $urandom_range(0, 9)));
        1: send_byte(CHAR_DQUOTE);
        default: send_byte(CHAR_SQUOTE);
      endcase
      n = $urandom_range(0, 6);
      repeat (n) send_byte(any_token_byte());
    end else if (kind < 92) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(any_token_byte());
    end else begin
      n = $urandom_range(12, 19);
      repeat (n) send_byte(any_token_byte());
    end
    send_byte(($urandom_range(0, 99) < 35) ? CHAR_SEMI : any_space());
    if ($urandom_range(0, 6) == 0)
      send_byte(($urandom_range(0, 1) == 0) ? CHAR_SEMI : any_space());
  endtask

  task automatic test_keywords_and_operators();
    send_word("int", CHAR_TAB);
    send_word("string", CHAR_LF);
    send_word("bool", CHAR_VT);
    send_word("=", CHAR_FF);
    send_word("==", CHAR_CR);
    send_word("+", CHAR_SPACE);
    send_word("-", CHAR_SEMI);
    send_word("*", CHAR_SEMI);
    send_word("/", CHAR_SPACE);
    wait_drained();
  endtask

  task automatic test_leading_chars();
    send_word("Az", CHAR_SPACE);
    send_word("_9", CHAR_SEMI);
    send_word("$", CHAR_SPACE);
    send_word("07", CHAR_SPACE);
    send_word("\"", CHAR_SPACE);
    send_word("'", CHAR_SPACE);
    send_word("@", CHAR_SPACE);
    send_byte(CHAR_NUL);
    send_byte(8'hFF);
    send_byte(CHAR_SEMI);
    wait_drained();
  endtask

  task automatic test_semicolons();
    send_byte(CHAR_SEMI);
    send_byte(CHAR_SPACE);
    send_byte(CHAR_SEMI);
    send_byte(CHAR_SEMI);
    send_word("x", CHAR_SEMI);
    wait_drained();
  endtask

  task automatic test_store_full();
    send_word("abcdefghijklmn", CHAR_SPACE);
    send_word("ABCDEFGHIJKLMNOPQ", CHAR_SEMI);
    send_word("0123456789abcde", CHAR_TAB);
    wait_drained();
  endtask

  // hold results back long enough that the block backs up into its input
  task automatic test_receiver_hold();
    rx_hold_left = 80;
    repeat (25) send_word("v", CHAR_SEMI);
    wait_drained();
  endtask

  task automatic test_random_stream();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (sent_count < RANDOM_ITEMS) begin
      send_random_token();
      if ($urandom_range(0, 59) == 0) wait_drained();
      if ($urandom_range(0, 39) == 0) begin
        tx_idle_en = !tx_idle_en;
        rx_idle_en = $urandom_range(0, 1);
      end
    end
    wait_drained();
  endtask

  task automatic test_full_rate_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (sent_count < TOTAL_ITEMS) send_random_token();
    wait_drained();
  endtask

  initial begin
    foreach (tok_chars[i]) tok_chars[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_keywords_and_operators();
    test_leading_chars();
    test_semicolons();
    test_store_full();
    test_receiver_hold();
    test_random_stream();
    test_full_rate_stream();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ktc_pkg.sv
sv/ktc_front.sv
sv/ktc_fifo.sv
sv/ktc_back.sv
sv/keyword_token_classifier_top.sv
sim/keyword_token_classifier_top_tb.sv
